// ===== rtl/core/bpv_pkg.sv =====
// ----------------------------------------------------------------------------
// bpv_pkg
// Shared types, constants and codes for the packet verdict block.
// ----------------------------------------------------------------------------
`default_nettype none
package bpv_pkg;

  localparam int HOST_BUCKETS    = 256;
  localparam int SEGMENT_BUCKETS = 4;
  localparam int BUCKET_WAYS     = 4;

  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_DROP   = 2'd1;
  localparam logic [1:0] VERDICT_QUEUE  = 2'd2;

  localparam logic [1:0] MODE_BYPASS      = 2'd0;
  localparam logic [1:0] MODE_CLASSIFY    = 2'd1;
  localparam logic [1:0] MODE_BIND_BYPASS = 2'd2;
  localparam logic [1:0] MODE_BIND_CHECK  = 2'd3;
  localparam logic [1:0] MODE_RESET       = MODE_CLASSIFY;

  localparam logic       OP_CLASSIFY = 1'b0;
  localparam logic       OP_ADD      = 1'b1;

  localparam logic [15:0] LOCAL_MASK    = 16'hFFFF;
  localparam logic signed [17:0] JUMBO_PAYLOAD = 18'sd1480;
  // DNS port 53
  localparam logic [15:0] DNS_PORT      = 16'd53;
  localparam logic [4:0]  MARK_NONE     = 5'd0;
  localparam logic [4:0]  MARK_ACK      = 5'd21;
  localparam logic [4:0]  MARK_ICMP     = 5'd22;
  localparam logic [7:0]  WAN_DIGIT     = 8'h30;
  localparam logic [7:0]  MARK_DIGIT    = 8'h31;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        op;
    logic        lookup;
    logic [1:0]  verdict;
    logic [4:0]  mark_value;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
  } qitem_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/bpv_ifs.sv =====
// ----------------------------------------------------------------------------
// bpv channel interfaces
// Header input, verdict output and mode write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface bpv_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [7:0]  protocol;
  logic [3:0]  ip_header_words;
  logic [3:0]  tcp_offset_words;
  logic [3:0]  tcp_flags;
  logic [15:0] packet_length;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [47:0] src_mac;
  logic [7:0]  ingress_digit;
  modport source (output valid, op, src_ip, dst_ip, protocol, ip_header_words,
                  tcp_offset_words, tcp_flags, packet_length, src_port, dst_port,
                  src_mac, ingress_digit, input ready);
  modport sink (input valid, op, src_ip, dst_ip, protocol, ip_header_words,
                tcp_offset_words, tcp_flags, packet_length, src_port, dst_port,
                src_mac, ingress_digit, output ready);
endinterface

interface bpv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [4:0] mark_value;
  modport source (output valid, verdict, mark_value, input ready);
  modport sink (input valid, verdict, mark_value, output ready);
endinterface

interface bpv_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] filter_mode;
  modport source (output valid, filter_mode, input ready);
  modport sink (input valid, filter_mode, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bridge_packet_verdict_ipmac.sv =====
// ----------------------------------------------------------------------------
// bridge_packet_verdict_ipmac
// Verdict and mark per bridged IPv4 header, with an IP-to-MAC binding table.
// ----------------------------------------------------------------------------
// Path: a classify header passes the queue, the table read and the output
//   register in turn; a stall at the output holds the back end.
// Flow: the back end takes no new header until the read-then-evaluate
//   step of the last one on the single table port ends; the queue lets
//   the front take headers while the back end works.
// Reset: synchronous; then a clear pass over all HOST_BUCKETS * SEGMENT_BUCKETS
//   buckets (1024 by default) clears the table; no header is taken until it
//   ends. Mode writes are taken at any time; the mode resets to classify.
`default_nettype none
module bridge_packet_verdict_ipmac #(
  parameter int SEGMENT_BUCKETS = bpv_pkg::SEGMENT_BUCKETS,
  parameter int BUCKET_WAYS     = bpv_pkg::BUCKET_WAYS
) (
  input  wire logic clk,
  input  wire logic rst,
  bpv_in_if.sink    item,
  bpv_out_if.source result,
  bpv_cfg_if.sink   cfg
);

  logic [1:0]      filter_mode;
  bpv_pkg::qitem_t push_item;
  bpv_pkg::qitem_t head;
  logic            push;
  logic            pop;
  logic            not_empty;
  logic            full;
  logic            clearing;

  // Mode register: every write transfer lands at once
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= bpv_pkg::MODE_RESET;
    end else if (cfg.valid) begin
      filter_mode <= cfg.filter_mode;
    end
  end

  // Front: settle the table-free verdicts and tag items that need a lookup
  bpv_front u_front (
    .item        (item),
    .filter_mode (filter_mode),
    .q_full      (full),
    .clearing    (clearing),
    .push_item   (push_item),
    .push        (push)
  );

  // Hold work between the front and the table
  bpv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  // Back: read the bucket, then check the binding, pass on the front's verdict or write the add
  bpv_back #(
    .SEGMENT_BUCKETS (SEGMENT_BUCKETS),
    .BUCKET_WAYS     (BUCKET_WAYS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (not_empty),
    .q_item   (head),
    .q_pop    (pop),
    .clearing (clearing),
    .result   (result)
  );

endmodule
`default_nettype wire

// ===== rtl/core/bpv_front.sv =====
// ----------------------------------------------------------------------------
// bpv_front
// Accept headers and settle every verdict that needs no table lookup.
// ----------------------------------------------------------------------------
`default_nettype none
module bpv_front (
  bpv_in_if.sink          item,
  input  wire logic [1:0] filter_mode,
  input  wire logic       q_full,
  input  wire logic       clearing,
  output bpv_pkg::qitem_t push_item,
  output logic            push
);

  logic signed [17:0] payload;
  logic               local_hit;
  logic [1:0]         cls_verdict;
  logic [4:0]         cls_mark;

  assign item.ready = !q_full && !clearing;
  assign push       = item.valid && item.ready;

  assign payload   = 18'(item.packet_length) - 18'({item.ip_header_words, 2'b00})
                   - 18'({item.tcp_offset_words, 2'b00});
  assign local_hit = (item.src_ip[15:0] & bpv_pkg::LOCAL_MASK) ==
                     (item.dst_ip[15:0] & bpv_pkg::LOCAL_MASK);

  always_comb begin
    cls_verdict = bpv_pkg::VERDICT_ACCEPT;
    cls_mark    = bpv_pkg::MARK_NONE;
    case (item.protocol)
      bpv_pkg::PROTO_TCP: begin
        if (item.tcp_flags[0] || item.tcp_flags[2]) begin
          cls_verdict = bpv_pkg::VERDICT_ACCEPT;
        end else if (payload == 18'sd0) begin
          if (item.ingress_digit == bpv_pkg::MARK_DIGIT &&
              (item.tcp_flags[1] || item.tcp_flags[3])) begin
            cls_mark = bpv_pkg::MARK_ACK;
          end
        end else if (payload > bpv_pkg::JUMBO_PAYLOAD) begin
          cls_verdict = bpv_pkg::VERDICT_ACCEPT;
        end else begin
          cls_verdict = bpv_pkg::VERDICT_QUEUE;
        end
      end
      bpv_pkg::PROTO_UDP: begin
        if (item.src_port != bpv_pkg::DNS_PORT && item.dst_port != bpv_pkg::DNS_PORT) begin
          cls_verdict = bpv_pkg::VERDICT_QUEUE;
        end
      end
      bpv_pkg::PROTO_ICMP: begin
        cls_mark = bpv_pkg::MARK_ICMP;
      end
      default: begin
        cls_verdict = bpv_pkg::VERDICT_ACCEPT;
      end
    endcase
  end

  always_comb begin
    push_item.op         = item.op;
    push_item.src_ip     = item.src_ip;
    push_item.src_mac    = item.src_mac;
    push_item.lookup     = 1'b0;
    push_item.verdict    = bpv_pkg::VERDICT_ACCEPT;
    push_item.mark_value = bpv_pkg::MARK_NONE;
    if (filter_mode == bpv_pkg::MODE_CLASSIFY && !local_hit) begin
      push_item.verdict    = cls_verdict;
      push_item.mark_value = cls_mark;
    end else if (filter_mode != bpv_pkg::MODE_BYPASS && !local_hit &&
                 item.ingress_digit != bpv_pkg::WAN_DIGIT) begin
      push_item.lookup = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bpv_queue.sv =====
// ----------------------------------------------------------------------------
// bpv_queue
// Short FIFO between the front and the table back end.
// ----------------------------------------------------------------------------
`default_nettype none
module bpv_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bpv_pkg::qitem_t push_item,
  input  wire logic            pop,
  output bpv_pkg::qitem_t      head,
  output logic                 not_empty,
  output logic                 full
);

  localparam int PTR_W = (bpv_pkg::QUEUE_DEPTH > 1) ? $clog2(bpv_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(bpv_pkg::QUEUE_DEPTH + 1);

  bpv_pkg::qitem_t slots [bpv_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == CNT_W'(bpv_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(bpv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(bpv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bpv_back.sv =====
// ----------------------------------------------------------------------------
// bpv_back
// Binding table: clear pass, lookup for binding checks, add and update.
// ----------------------------------------------------------------------------
`default_nettype none
module bpv_back #(
  parameter int SEGMENT_BUCKETS = bpv_pkg::SEGMENT_BUCKETS,
  parameter int BUCKET_WAYS     = bpv_pkg::BUCKET_WAYS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire bpv_pkg::qitem_t q_item,
  output logic                 q_pop,
  output logic                 clearing,
  bpv_out_if.source            result
);

  localparam int BUCKETS  = bpv_pkg::HOST_BUCKETS * SEGMENT_BUCKETS;
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int WAY_W    = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

  bpv_pkg::entry_t [BUCKET_WAYS-1:0] table_mem [BUCKETS];
  bpv_pkg::entry_t [BUCKET_WAYS-1:0] rd_row;
  bpv_pkg::entry_t [BUCKET_WAYS-1:0] wr_row;
  logic [BUCKET_W-1:0]  wr_addr;
  logic                 mem_we;

  logic [7:0] seg_tab [256];
  logic [BUCKET_W-1:0]  q_bucket;
  logic [BUCKET_W-1:0]  cur_bucket;
  bpv_pkg::qitem_t      cur;
  logic [BUCKET_W-1:0]  clr_addr;

  bpv_pkg::back_state_t state, state_next;

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             free;
  logic [WAY_W-1:0] free_way;
  logic             load;
  logic [1:0]       load_verdict;
  logic             res_valid;
  logic [1:0]       res_verdict;
  logic [4:0]       res_mark;

  for (genvar i = 0; i < 256; i++) begin : g_seg
    assign seg_tab[i] = 8'(i % SEGMENT_BUCKETS);
  end

  assign q_bucket = BUCKET_W'({seg_tab[q_item.src_ip[23:16]], q_item.src_ip[31:24]});
  assign clearing = state == bpv_pkg::S_CLEAR;

  // Compare all ways of the bucket side by side
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
      if (rd_row[w].valid && rd_row[w].ip == cur.src_ip) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!rd_row[w].valid) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bpv_pkg::S_CLEAR: begin
        if (clr_addr == BUCKET_W'(BUCKETS - 1)) begin
          state_next = bpv_pkg::S_IDLE;
        end
      end
      bpv_pkg::S_IDLE: begin
        if (q_pop) begin
          state_next = bpv_pkg::S_EVAL;
        end
      end
      bpv_pkg::S_EVAL: begin
        state_next = bpv_pkg::S_IDLE;
      end
      default: begin
        state_next = bpv_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    wr_addr      = cur_bucket;
    wr_row       = rd_row;
    load         = 1'b0;
    load_verdict = cur.verdict;
    case (state)
      bpv_pkg::S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
          wr_row[w]       = rd_row[w];
          wr_row[w].valid = 1'b0;
        end
      end
      bpv_pkg::S_IDLE: begin
        q_pop = q_valid && (!res_valid || result.ready);
      end
      bpv_pkg::S_EVAL: begin
        if (cur.op == bpv_pkg::OP_ADD) begin
          if (hit) begin
            mem_we              = 1'b1;
            wr_row[hit_way].mac = cur.src_mac;
          end else if (free) begin
            mem_we                 = 1'b1;
            wr_row[free_way].valid = 1'b1;
            wr_row[free_way].ip    = cur.src_ip;
            wr_row[free_way].mac   = cur.src_mac;
          end
        end else begin
          load = 1'b1;
          if (cur.lookup) begin
            load_verdict = (hit && rd_row[hit_way].mac == cur.src_mac) ?
                           bpv_pkg::VERDICT_ACCEPT : bpv_pkg::VERDICT_DROP;
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_addr] <= wr_row;
    end
    if (q_pop) begin
      rd_row <= table_mem[q_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur        <= q_item;
      cur_bucket <= q_bucket;
    end
    if (load) begin
      res_verdict <= load_verdict;
      res_mark    <= cur.mark_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpv_pkg::S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      res_valid <= load || (res_valid && !result.ready);
    end
  end

  assign result.valid      = res_valid;
  assign result.verdict    = res_verdict;
  assign result.mark_value = res_mark;

endmodule
`default_nettype wire
